FILE: design/http_request_header_parser_defines.svh
// Assertion macros shared by the parser modules.
// Every macro samples on clk and stays quiet while rst_n is low.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/hrhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  localparam int MAX_NAME_LEN = 16;
  localparam int POS_W        = $clog2(MAX_NAME_LEN + 1);

  localparam int NUM_METHODS  = 5;
  localparam int NUM_HEADERS  = 11;
  localparam int CAND_W       = NUM_HEADERS;
  localparam int IDX_W        = $clog2(NUM_HEADERS);

  // Longest known name is 15 characters; names are stored left justified.
  localparam int NAME_CHARS   = 16;
  localparam int NAME_BITS    = NAME_CHARS * 8;
  localparam int CHAR_AW      = $clog2(NAME_CHARS);

  localparam int TYPE_W       = 3;
  localparam int METH_W       = 3;
  localparam int HDR_W        = 4;

  localparam int DEPTH        = 4;
  localparam int Q_AW         = $clog2(DEPTH);
  localparam int Q_CW         = $clog2(DEPTH + 1);

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [CAND_W-1:0] METH_ALL = CAND_W'((1 << NUM_METHODS) - 1);
  localparam logic [CAND_W-1:0] HDR_ALL  = CAND_W'((1 << NUM_HEADERS) - 1);

  typedef enum logic [TYPE_W-1:0] {
    ITEM_METHOD      = 3'd0,
    ITEM_URL_BYTE    = 3'd1,
    ITEM_VALUE_BYTE  = 3'd2,
    ITEM_URL_END     = 3'd3,
    ITEM_VALUE_END   = 3'd4
  } item_t;

  typedef struct packed {
    item_t             item_type;
    logic [METH_W-1:0] method_code;
    logic [HDR_W-1:0]  header_code;
    logic [7:0]        data;
    logic              last;
  } res_t;

  // Results of one accepted byte: count, then up to two items in order.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [CAND_W-1:0] keep;
    logic              hit;
    logic [IDX_W-1:0]  idx;
  } match_t;

  function automatic logic [NAME_BITS-1:0] name_text(input logic hdr,
                                                     input logic [IDX_W-1:0] idx);
    logic [NAME_BITS-1:0] t;
    t = '0;
    if (hdr) begin
      case (idx)
        4'd0:    t = {"host",            {(NAME_CHARS - 4){8'h00}}};
        4'd1:    t = {"user-agent",      {(NAME_CHARS - 10){8'h00}}};
        4'd2:    t = {"accept",          {(NAME_CHARS - 6){8'h00}}};
        4'd3:    t = {"accept-charset",  {(NAME_CHARS - 14){8'h00}}};
        4'd4:    t = {"accept-encoding", {(NAME_CHARS - 15){8'h00}}};
        4'd5:    t = {"accept-language", {(NAME_CHARS - 15){8'h00}}};
        4'd6:    t = {"connection",      {(NAME_CHARS - 10){8'h00}}};
        4'd7:    t = {"content-type",    {(NAME_CHARS - 12){8'h00}}};
        4'd8:    t = {"content-length",  {(NAME_CHARS - 14){8'h00}}};
        4'd9:    t = {"authorization",   {(NAME_CHARS - 13){8'h00}}};
        4'd10:   t = {"from",            {(NAME_CHARS - 4){8'h00}}};
        default: t = '0;
      endcase
    end else begin
      case (idx)
        4'd0:    t = {"get",     {(NAME_CHARS - 3){8'h00}}};
        4'd1:    t = {"post",    {(NAME_CHARS - 4){8'h00}}};
        4'd2:    t = {"connect", {(NAME_CHARS - 7){8'h00}}};
        4'd3:    t = {"put",     {(NAME_CHARS - 3){8'h00}}};
        4'd4:    t = {"head",    {(NAME_CHARS - 4){8'h00}}};
        default: t = '0;
      endcase
    end
    return t;
  endfunction

  function automatic logic [POS_W-1:0] name_len(input logic hdr,
                                                input logic [IDX_W-1:0] idx);
    logic [POS_W-1:0] l;
    l = '0;
    if (hdr) begin
      case (idx)
        4'd0:    l = POS_W'(4);
        4'd1:    l = POS_W'(10);
        4'd2:    l = POS_W'(6);
        4'd3:    l = POS_W'(14);
        4'd4:    l = POS_W'(15);
        4'd5:    l = POS_W'(15);
        4'd6:    l = POS_W'(10);
        4'd7:    l = POS_W'(12);
        4'd8:    l = POS_W'(14);
        4'd9:    l = POS_W'(13);
        4'd10:   l = POS_W'(4);
        default: l = '0;
      endcase
    end else begin
      case (idx)
        4'd0:    l = POS_W'(3);
        4'd1:    l = POS_W'(4);
        4'd2:    l = POS_W'(7);
        4'd3:    l = POS_W'(3);
        4'd4:    l = POS_W'(4);
        default: l = '0;
      endcase
    end
    return l;
  endfunction

  function automatic logic [7:0] name_char(input logic hdr,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [CHAR_AW-1:0] ci);
    logic [NAME_BITS-1:0] t;
    t = name_text(hdr, idx) << (8 * ci);
    return t[NAME_BITS-1 -: 8];
  endfunction

endpackage

`default_nettype wire

FILE: design/hrhp_match.sv
`timescale 1ns / 1ps
`default_nettype none

module hrhp_match (
  input  logic                        seen,
  input  logic [hrhp_pkg::POS_W-1:0]  pos,
  input  logic [hrhp_pkg::CAND_W-1:0] mask,
  input  logic [7:0]                  data,
  output hrhp_pkg::match_t            res
);
  import hrhp_pkg::*;

  logic [7:0]        folded;
  logic [CAND_W-1:0] full;
  logic [POS_W-1:0]  len;

  // Fold ASCII upper case only.
  assign folded = (data >= CH_UPPER_A && data <= CH_UPPER_Z) ? data + CASE_DIFF : data;

  always_comb begin
    res  = '0;
    full = '0;
    len  = '0;
    for (int i = 0; i < CAND_W; i++) begin
      len        = name_len(seen, IDX_W'(i));
      res.keep[i] = mask[i] && (pos < len) &&
                    (name_char(seen, IDX_W'(i), pos[CHAR_AW-1:0]) == folded);
      full[i]    = mask[i] && (len == pos);
    end
    // Lowest index wins.
    for (int i = CAND_W - 1; i >= 0; i--) begin
      if (full[i]) begin
        res.idx = IDX_W'(i);
      end
    end
    res.hit = |full;
  end

endmodule

`default_nettype wire

FILE: design/hrhp_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_header_parser_defines.svh"

module hrhp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_data,
  input  logic              in_eor,
  output hrhp_pkg::push_t   push
);
  import hrhp_pkg::*;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_SKIPLINE,
    PH_URL,
    PH_SKIPONE,
    PH_VALUE,
    PH_STOP
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CAND_W-1:0] mask_r, mask_nxt;
  logic              seen_r, seen_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;

  match_t            mt;
  res_t              step_item, eor_item;
  logic              step_has, eor_has;
  logic [7:0]        delim;

  hrhp_match u_match (
    .seen (seen_r),
    .pos  (pos_r),
    .mask (mask_r),
    .data (in_data),
    .res  (mt)
  );

  assign delim = seen_r ? CH_COLON : CH_SPACE;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    mask_nxt  = mask_r;
    seen_nxt  = seen_r;
    hdr_nxt   = hdr_r;
    step_item = '0;
    step_has  = 1'b0;
    eor_item  = '0;
    eor_has   = 1'b0;
    push      = '0;

    case (phase_r)
      PH_SEEK: begin
        if (in_data == CH_LF) begin
          if (pos_r == '0) begin
            phase_nxt = PH_STOP;
          end else begin
            phase_nxt = PH_SEEK;
            pos_nxt   = '0;
            mask_nxt  = seen_r ? HDR_ALL : METH_ALL;
          end
        end else if (in_data == delim) begin
          if (!mt.hit) begin
            phase_nxt = PH_SKIPLINE;
          end else if (!seen_r) begin
            step_has              = 1'b1;
            step_item.item_type   = ITEM_METHOD;
            step_item.method_code = METH_W'(mt.idx);
            seen_nxt              = 1'b1;
            phase_nxt             = PH_URL;
          end else begin
            hdr_nxt   = HDR_W'(mt.idx);
            phase_nxt = PH_SKIPONE;
          end
        end else begin
          mask_nxt = mt.keep;
          if (pos_r < POS_W'(MAX_NAME_LEN)) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (mt.keep == '0) begin
            phase_nxt = PH_SKIPLINE;
          end
        end
      end
      PH_SKIPLINE: begin
        if (in_data == CH_LF) begin
          phase_nxt = PH_SEEK;
          pos_nxt   = '0;
          mask_nxt  = seen_r ? HDR_ALL : METH_ALL;
        end
      end
      PH_URL: begin
        step_has = 1'b1;
        if (in_data == CH_LF) begin
          step_item.item_type = ITEM_URL_END;
          phase_nxt           = PH_SEEK;
          pos_nxt             = '0;
          mask_nxt            = HDR_ALL;
        end else begin
          step_item.item_type = ITEM_URL_BYTE;
          step_item.data      = in_data;
        end
      end
      PH_SKIPONE: begin
        if (in_data == CH_LF) begin
          step_has              = 1'b1;
          step_item.item_type   = ITEM_VALUE_END;
          step_item.header_code = hdr_r;
          phase_nxt             = PH_SEEK;
          pos_nxt               = '0;
          mask_nxt              = HDR_ALL;
        end else begin
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        step_has              = 1'b1;
        step_item.header_code = hdr_r;
        if (in_data == CH_LF) begin
          step_item.item_type = ITEM_VALUE_END;
          phase_nxt           = PH_SEEK;
          pos_nxt             = '0;
          mask_nxt            = HDR_ALL;
        end else begin
          step_item.item_type = ITEM_VALUE_BYTE;
          step_item.data      = in_data;
        end
      end
      default: begin
      end
    endcase

    // Close an open field on the final byte, then return to reset state.
    if (in_eor) begin
      if (phase_nxt == PH_URL) begin
        eor_has            = 1'b1;
        eor_item.item_type = ITEM_URL_END;
      end else if (phase_nxt == PH_SKIPONE || phase_nxt == PH_VALUE) begin
        eor_has              = 1'b1;
        eor_item.item_type   = ITEM_VALUE_END;
        eor_item.header_code = hdr_nxt;
      end
      phase_nxt = PH_SEEK;
      pos_nxt   = '0;
      mask_nxt  = METH_ALL;
      seen_nxt  = 1'b0;
      hdr_nxt   = '0;
    end

    if (in_fire) begin
      push.n = {1'b0, step_has} + {1'b0, eor_has};
      if (step_has && eor_has) begin
        push.r0      = step_item;
        push.r1      = eor_item;
        push.r1.last = 1'b1;
      end else if (step_has) begin
        push.r0      = step_item;
        push.r0.last = 1'b1;
      end else if (eor_has) begin
        push.r0      = eor_item;
        push.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      pos_r   <= '0;
      mask_r  <= METH_ALL;
      seen_r  <= 1'b0;
      hdr_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      mask_r  <= mask_nxt;
      seen_r  <= seen_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  `ASSERT_NEXT(a_eor_restart, in_fire && in_eor, phase_r == PH_SEEK && !seen_r && pos_r == '0)
  `ASSERT_CLK(a_url_after_method, phase_r != PH_URL || seen_r)
  `ASSERT_CLK(a_mask_in_range, seen_r || (mask_r & ~METH_ALL) == '0)

endmodule

`default_nettype wire

FILE: design/hrhp_outq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_header_parser_defines.svh"

module hrhp_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  hrhp_pkg::push_t  push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output hrhp_pkg::res_t   head
);
  import hrhp_pkg::*;

  res_t            q_r [DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            pop;
  logic [Q_AW-1:0] wr_ptr_1;

  // Take a byte only when both of its possible results fit.
  assign room      = cnt_r <= Q_CW'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign head      = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_1  = wr_ptr_r + 1'b1;

  assign wr_ptr_nxt = wr_ptr_r + Q_AW'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
  assign cnt_nxt    = cnt_r + Q_CW'(push.n) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != '0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= Q_CW'(DEPTH))
  `ASSERT_CLK(a_pair_last, push.n != 2'd2 || (!push.r0.last && push.r1.last))
  `ASSERT_NEXT(a_pop_drains, pop && push.n == '0, cnt_r + 1'b1 == $past(cnt_r))

endmodule

`default_nettype wire

FILE: design/http_request_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// HTTP request header parser. Takes one request byte per clock while in_stall is
// low and emits method, URL byte, header value byte and field end items. The
// results of an accepted byte are written into a four-entry output queue, whose
// oldest entry is offered on the out_ channel. in_stall rises while fewer than
// two queue entries are free, so with an unstalled consumer the block keeps one
// byte per cycle. Only the final byte of a request can give two results (its own
// plus the close of an open URL or value), which are queued together. Name
// matching runs all candidate names in parallel against the stored position, so
// the parser state is updated on each accepted byte.
module http_request_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_request,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_item_type,
  output logic [2:0] out_method_code,
  output logic [3:0] out_header_code,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);
  import hrhp_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  in_fire;

  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  hrhp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data_byte),
    .in_eor  (in_end_of_request),
    .push    (push)
  );

  hrhp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_item_type   = TYPE_W'(head.item_type);
  assign out_method_code = head.method_code;
  assign out_header_code = head.header_code;
  assign out_byte        = head.data;
  assign out_last_of_run = head.last;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hrhp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_GAP      = 18;
  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_BYTES = 1050;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 50;

  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [15:0] METHOD_SET = 16'h001F;
  localparam logic [15:0] HEADER_SET = 16'h07FF;

  typedef enum logic [2:0] {
    P_SEEK,
    P_SKIP_LINE,
    P_URL,
    P_SKIP_ONE,
    P_VALUE,
    P_STOPPED
  } scan_t;

  typedef struct {
    item_t      kind;
    logic [2:0] meth;
    logic [3:0] hdr;
    logic [7:0] data;
    logic       last;
  } parse_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_end_of_request;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_item_type;
  logic [2:0] out_method_code;
  logic [3:0] out_header_code;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  // Parser state as predicted from the accepted bytes.
  scan_t       sc_phase;
  int          sc_pos;
  logic [15:0] sc_cand;
  bit          sc_seen;
  logic [3:0]  sc_hdr;

  parse_item_t results_due[$];
  parse_item_t due;
  logic [7:0]  req_bytes[$];

  bit src_idle;
  bit sink_idle;
  int sink_hold;
  int bytes_taken;
  int mismatches;
  int quiet_cycles;

  http_request_header_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_request (in_end_of_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_type     (out_item_type),
    .out_method_code   (out_method_code),
    .out_header_code   (out_header_code),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run)
  );

  always #10 clk = ~clk;

  function automatic string known_name(bit hdr, int idx);
    if (!hdr) begin
      case (idx)
        0: return "get";
        1: return "post";
        2: return "connect";
        3: return "put";
        4: return "head";
        default: return "";
      endcase
    end
    case (idx)
      0:  return "host";
      1:  return "user-agent";
      2:  return "accept";
      3:  return "accept-charset";
      4:  return "accept-encoding";
      5:  return "accept-language";
      6:  return "connection";
      7:  return "content-type";
      8:  return "content-length";
      9:  return "authorization";
      10: return "from";
      default: return "";
    endcase
  endfunction

  function automatic void restart_line();
    sc_phase = P_SEEK;
    sc_pos   = 0;
    sc_cand  = sc_seen ? HEADER_SET : METHOD_SET;
  endfunction

  function automatic void narrow_names(logic [7:0] c);
    string      nm;
    logic [7:0] low;
    int         cnt;
    int         i;
    cnt = sc_seen ? NUM_HEADERS : NUM_METHODS;
    low = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_DIFF : c;
    for (i = 0; i < cnt; i++) begin
      if (sc_cand[i]) begin
        nm = known_name(sc_seen, i);
        if (sc_pos >= nm.len() || 8'(nm[sc_pos]) != low)
          sc_cand[i] = 1'b0;
      end
    end
    if (sc_pos < MAX_NAME_LEN)
      sc_pos++;
  endfunction

  function automatic int matched_name();
    string nm;
    int    cnt;
    int    i;
    cnt = sc_seen ? NUM_HEADERS : NUM_METHODS;
    for (i = 0; i < cnt; i++) begin
      nm = known_name(sc_seen, i);
      if (sc_cand[i] && nm.len() == sc_pos)
        return i;
    end
    return -1;
  endfunction

  function automatic parse_item_t make_item(item_t kind, logic [2:0] meth,
                                            logic [3:0] hdr, logic [7:0] data);
    parse_item_t it;
    it.kind = kind;
    it.meth = meth;
    it.hdr  = hdr;
    it.data = data;
    it.last = 1'b0;
    return it;
  endfunction

  // Advance the predicted parser by one byte and queue the items it yields.
  function automatic void parse_byte(logic [7:0] b, logic eor);
    parse_item_t batch[$];
    logic [7:0]  delim;
    int          m;
    int          k;
    delim = sc_seen ? CH_COLON : CH_SPACE;
    case (sc_phase)
      P_SEEK: begin
        if (b == CH_LF) begin
          if (sc_pos == 0) sc_phase = P_STOPPED;
          else restart_line();
        end else if (b == delim) begin
          m = matched_name();
          if (m < 0) begin
            sc_phase = P_SKIP_LINE;
          end else if (!sc_seen) begin
            batch.push_back(make_item(ITEM_METHOD, 3'(m), 4'd0, 8'd0));
            sc_seen  = 1'b1;
            sc_phase = P_URL;
          end else begin
            sc_hdr   = 4'(m);
            sc_phase = P_SKIP_ONE;
          end
        end else begin
          narrow_names(b);
          if (sc_cand == '0) sc_phase = P_SKIP_LINE;
        end
      end
      P_SKIP_LINE: begin
        if (b == CH_LF) restart_line();
      end
      P_URL: begin
        if (b == CH_LF) begin
          batch.push_back(make_item(ITEM_URL_END, 3'd0, 4'd0, 8'd0));
          restart_line();
        end else begin
          batch.push_back(make_item(ITEM_URL_BYTE, 3'd0, 4'd0, b));
        end
      end
      P_SKIP_ONE: begin
        if (b == CH_LF) begin
          batch.push_back(make_item(ITEM_VALUE_END, 3'd0, sc_hdr, 8'd0));
          restart_line();
        end else begin
          sc_phase = P_VALUE;
        end
      end
      P_VALUE: begin
        if (b == CH_LF) begin
          batch.push_back(make_item(ITEM_VALUE_END, 3'd0, sc_hdr, 8'd0));
          restart_line();
        end else begin
          batch.push_back(make_item(ITEM_VALUE_BYTE, 3'd0, sc_hdr, b));
        end
      end
      default: ;
    endcase

    // Close whatever field is still open at end of request, then start over.
    if (eor) begin
      if (sc_phase == P_URL)
        batch.push_back(make_item(ITEM_URL_END, 3'd0, 4'd0, 8'd0));
      else if (sc_phase == P_SKIP_ONE || sc_phase == P_VALUE)
        batch.push_back(make_item(ITEM_VALUE_END, 3'd0, sc_hdr, 8'd0));
      sc_seen = 1'b0;
      sc_hdr  = 4'd0;
      restart_line();
    end

    if (batch.size() > 0)
      batch[batch.size() - 1].last = 1'b1;
    for (k = 0; k < batch.size(); k++)
      results_due.push_back(batch[k]);
  endfunction

  task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
    if (mismatches < PRINT_CAP)
      $display("ERROR at %0t: %s expected %h got %h", $time, field, want, got);
    mismatches++;
  endtask

  // Sender: called at a falling edge, returns at the falling edge after the transfer.
  task automatic send_byte(logic [7:0] b, logic eor);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_end_of_request <= eor;
    do @(posedge clk); while (in_stall);
    parse_byte(b, eor);
    bytes_taken++;
    @(negedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    req_bytes.push_back(b);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++)
      req_bytes.push_back(8'(s[i]));
  endfunction

  // Append a name with its letters in random case.
  function automatic void add_name(string s);
    logic [7:0] c;
    int         i;
    for (i = 0; i < s.len(); i++) begin
      c = 8'(s[i]);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1))
        c = c - CASE_DIFF;
      req_bytes.push_back(c);
    end
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
    return b;
  endfunction

  function automatic void add_value(int n);
    repeat (n) req_bytes.push_back(text_byte());
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 1)) req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return CH_LF;
      1: return CH_SPACE;
      2: return CH_COLON;
      3: return 8'($urandom_range(8'h61, 8'h7A));
      4: return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Line with a made-up name: may be empty, over long, or lack the colon.
  function automatic void add_junk_line();
    int n;
    n = $urandom_range(0, 22);
    repeat (n) req_bytes.push_back($urandom_range(0, 7) == 0 ? 8'h2D :
                                   8'($urandom_range(8'h41, 8'h7A)));
    if ($urandom_range(0, 2) != 0) begin
      req_bytes.push_back($urandom_range(0, 1) ? CH_COLON : CH_SPACE);
      add_value($urandom_range(0, 6));
    end
    add_eol();
  endfunction

  // Send the built request; end of request on the last byte or on a random one.
  task automatic send_request(bit cut_short);
    int stop_at;
    int i;
    stop_at = req_bytes.size() - 1;
    if (cut_short)
      stop_at = $urandom_range(0, stop_at);
    for (i = 0; i <= stop_at; i++)
      send_byte(req_bytes[i], i == stop_at);
    req_bytes.delete();
  endtask

  task automatic test_methods();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    add_text("GET /\n\n");
    send_request(1'b0);
    add_text("pOsT /f?a=1\r\n\n");
    send_request(1'b0);
    add_text("CONNECT h:443\n\n");
    send_request(1'b0);
    // method line with nothing after the space
    add_text("put \n\n");
    send_request(1'b0);
    add_text("hEaD /");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_text("\n\n");
    send_request(1'b0);
  endtask

  task automatic test_headers();
    int i;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    add_text("GET /\n");
    for (i = 0; i < NUM_HEADERS; i++) begin
      add_name(known_name(1'b1, i));
      add_text(": v");
      add_byte(8'h80 + 8'(i));
      add_text("\r\n");
    end
    add_text("x-unknown: 1\n");
    add_text("no colon here\n");
    add_text(":empty name\n");
    add_text("accept-languages-too-long: z\n");
    // colon at line end, then colon followed by a single byte
    add_text("from:\n");
    add_text("host: \n");
    add_text("\n");
    send_request(1'b0);
  endtask

  task automatic test_corner_cases();
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    // last line without newline: URL open at end of request
    add_text("GET /ab");
    send_request(1'b0);
    add_text("get /\nHost: ab");
    send_request(1'b0);
    add_text("get /\nhost:");
    send_request(1'b0);
    add_text("get /\nhost: ");
    send_request(1'b0);
    sink_idle = 1'b1;
    // empty line before any method line stops everything
    add_text("\nGET /x\n\n");
    send_request(1'b0);
    add_text("GET /\n\nHost: x\n");
    send_request(1'b0);
    add_text("GET\nXGET /\nGET/x\n@et /\n[et /\nget /q\n\n");
    send_request(1'b0);
    add_text("G");
    send_request(1'b0);
    add_text("GET /\nhost x\nHOST:\tv\n");
    send_request(1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold = LONG_HOLD;
    add_text("POST /");
    for (i = 0; i < 40; i++)
      add_byte(8'h21 + 8'(i));
    add_text("\n\n");
    send_request(1'b0);
  endtask

  task automatic test_random_requests();
    int start;
    int lines;
    start = bytes_taken;
    while (bytes_taken < start + RANDOM_BYTES) begin
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30)) add_byte(noise_byte());
      end else begin
        if ($urandom_range(0, 5) == 0) add_junk_line();
        add_name(known_name(1'b0, $urandom_range(0, NUM_METHODS - 1)));
        add_byte($urandom_range(0, 9) == 0 ? noise_byte() : CH_SPACE);
        add_value($urandom_range(0, 12));
        add_eol();
        lines = $urandom_range(0, 6);
        repeat (lines) begin
          if ($urandom_range(0, 7) == 0) begin
            add_junk_line();
          end else begin
            add_name(known_name(1'b1, $urandom_range(0, NUM_HEADERS - 1)));
            if ($urandom_range(0, 9) == 0) add_byte(noise_byte());
            add_byte(CH_COLON);
            if ($urandom_range(0, 3) != 0) add_byte(CH_SPACE);
            add_value($urandom_range(0, 10));
            add_eol();
          end
        end
        add_byte(CH_LF);
        // body bytes after the blank line are ignored
        if ($urandom_range(0, 3) == 0) add_value($urandom_range(1, 8));
      end
      send_request($urandom_range(0, 4) == 0);
    end
  endtask

  // Receiver: per result, hold off for a random wait while sink_idle is set; a nonzero sink_hold gives one long wait.
  initial begin
    int w;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        w = sink_hold;
        sink_hold = 0;
      end else begin
        w = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none pending, item_type", 8'h00, 8'(out_item_type));
      end else begin
        due = results_due.pop_front();
        if (out_item_type !== due.kind)
          report_mismatch("item_type", 8'(due.kind), 8'(out_item_type));
        if (out_method_code !== due.meth)
          report_mismatch("method_code", 8'(due.meth), 8'(out_method_code));
        if (out_header_code !== due.hdr)
          report_mismatch("header_code", 8'(due.hdr), 8'(out_header_code));
        if (out_byte !== due.data)
          report_mismatch("out_byte", due.data, out_byte);
        if (out_last_of_run !== due.last)
          report_mismatch("last_of_run", 8'(due.last), 8'(out_last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_end_of_request = 1'b0;
    src_idle          = 1'b0;
    sink_idle         = 1'b0;
    sink_hold         = 0;
    bytes_taken       = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    sc_seen           = 1'b0;
    sc_hdr            = 4'd0;
    restart_line();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_methods();
    test_headers();
    test_corner_cases();
    test_backpressure();
    test_random_requests();

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
